// ----- rtl/core/cdq_pkg.sv -----
// Shared types, constants and helper functions of the subcode Q generator.
package cdq_pkg;

  typedef struct packed {
    logic               mode;
    logic [6:0]         track_number;
    logic signed [19:0] track_start;
    logic [19:0]        lead_in_length;
    logic [19:0]        track_sectors;
    logic [19:0]        track_postgap;
    logic [3:0]         track_control;
    logic signed [19:0] query_address;
  } cdq_in_t;

  typedef struct packed {
    logic [63:0] subcode_word;
    logic        last;
    logic        found;
    logic [6:0]  found_track;
  } cdq_out_t;

  // Classified request passed from the front end to the back end.
  typedef struct packed {
    logic    is_query;
    logic    load_ok;
    cdq_in_t pl;
  } cdq_cmd_t;

  typedef struct packed {
    logic [19:0] start;
    logic [19:0] lead_in;
    logic [19:0] length;
    logic [19:0] postgap;
    logic [3:0]  control;
  } cdq_entry_t;

  localparam logic       MODE_LOAD        = 1'b0;
  localparam logic       CFG_WIN_START    = 1'b0;
  localparam logic       CFG_TRACK_COUNT  = 1'b1;
  localparam logic [6:0] WIN_START_RST    = 7'd1;
  localparam logic [6:0] FRAMES_PER_SEC   = 7'd75;
  localparam logic [6:0] SECS_PER_MIN     = 7'd60;
  localparam int         LEAD_OFS         = 150;
  localparam int         ABS_WRAP         = 450000;
  localparam logic [3:0] ADR_POSITION     = 4'h1;
  localparam logic [15:0] CRC_POLY        = 16'h1021;
  localparam int         Q_BYTES          = 12;
  localparam int         CRC_BYTES        = 10;

  // Two-digit BCD of a value below 256, taken modulo 100.
  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [7:0]  m;
    logic [15:0] p;
    logic [3:0]  tens;
    logic [7:0]  ones;
    if (v >= 8'd200) begin
      m = v - 8'd200;
    end else if (v >= 8'd100) begin
      m = v - 8'd100;
    end else begin
      m = v;
    end
    p    = {8'd0, m} * 16'd103;
    tens = p[13:10];
    ones = m - ({4'd0, tens} * 8'd10);
    return {tens, ones[3:0]};
  endfunction

  // One byte of the CRC-16 (x^16 + x^12 + x^5 + 1), MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'd0};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/cdq_front.sv -----
// Front end: takes input requests and classifies them as loads or queries.
module cdq_front #(
  parameter int MAX_TRACKS = 99
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cdq_pkg::cdq_in_t  in_data,
  input  logic              q_full,
  output logic              push,
  output cdq_pkg::cdq_cmd_t push_cmd
);
  import cdq_pkg::*;

  logic     hold_r, hold_nxt;
  cdq_cmd_t cmd_r, cmd_nxt;
  logic     accept;

  assign in_stall = hold_r & q_full;
  assign accept   = in_valid & ~in_stall;
  assign push     = hold_r & ~q_full;
  assign push_cmd = cmd_r;

  always_comb begin
    hold_nxt = hold_r;
    cmd_nxt  = cmd_r;
    if (accept) begin
      hold_nxt         = 1'b1;
      cmd_nxt.pl       = in_data;
      cmd_nxt.is_query = (in_data.mode != MODE_LOAD);
      cmd_nxt.load_ok  = (in_data.track_number != 7'd0) &&
                         ({1'b0, in_data.track_number} <= 8'(MAX_TRACKS));
    end else if (push) begin
      hold_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule

// ----- rtl/core/cdq_queue.sv -----
// Two-entry request queue between the front end and the back end.
module cdq_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cdq_pkg::cdq_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output cdq_pkg::cdq_cmd_t q_cmd
);
  import cdq_pkg::*;

  cdq_cmd_t    slot_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/core/cdq_divider.sv -----
// Divider by 75 or 60 through a scaled reciprocal multiply and a remainder step.
module cdq_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [20:0] dividend,
  input  logic [6:0]  divisor,
  output logic        done,
  output logic [20:0] quot,
  output logic [6:0]  rem
);
  import cdq_pkg::*;

  // Reciprocals scaled by 2^28; the quotient is exact for every 21-bit dividend.
  localparam int          RECIP_SHIFT  = 28;
  localparam logic [22:0] RECIP_FRAMES = 23'd3579140;
  localparam logic [22:0] RECIP_SECS   = 23'd4473925;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL  = 2'd1;
  localparam logic [1:0] P_REM  = 2'd2;

  logic [1:0]  phase_r, phase_nxt;
  logic        done_r, done_nxt;
  logic [20:0] n_r, n_nxt, q_r, q_nxt;
  logic [6:0]  d_r, d_nxt, rem_r, rem_nxt;
  logic [22:0] recip_r, recip_nxt;
  logic [43:0] prod;
  logic [27:0] back_prod;
  logic [20:0] diff;

  assign prod      = {21'd0, recip_r} * {23'd0, n_r};
  assign back_prod = {7'd0, q_r} * {21'd0, d_r};
  assign diff      = n_r - back_prod[20:0];
  assign done      = done_r;
  assign quot      = q_r;
  assign rem       = rem_r;

  always_comb begin
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    n_nxt     = n_r;
    q_nxt     = q_r;
    d_nxt     = d_r;
    rem_nxt   = rem_r;
    recip_nxt = recip_r;
    if (start) begin
      phase_nxt = P_MUL;
      n_nxt     = dividend;
      d_nxt     = divisor;
      recip_nxt = (divisor == FRAMES_PER_SEC) ? RECIP_FRAMES : RECIP_SECS;
    end else begin
      unique case (phase_r)
        P_MUL: begin
          q_nxt     = {5'd0, prod[43:RECIP_SHIFT]};
          phase_nxt = P_REM;
        end
        P_REM: begin
          rem_nxt   = diff[6:0];
          phase_nxt = P_IDLE;
          done_nxt  = 1'b1;
        end
        default: begin
          phase_nxt = P_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
    n_r     <= n_nxt;
    q_r     <= q_nxt;
    d_r     <= d_nxt;
    rem_r   <= rem_nxt;
    recip_r <= recip_nxt;
  end

endmodule

// ----- rtl/core/cdq_back.sv -----
// Back end: track table, track search, MSF conversion, CRC and result output.
module cdq_back #(
  parameter int MAX_TRACKS = 99
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [6:0]        cfg_wdata,
  input  logic              q_valid,
  input  cdq_pkg::cdq_cmd_t q_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output cdq_pkg::cdq_out_t out_data
);
  import cdq_pkg::*;

  localparam int IW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_PCHK = 4'd3;
  localparam logic [3:0] S_PREP = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_CRC  = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;
  localparam logic [3:0] S_MISS = 4'd8;

  cdq_entry_t mem [MAX_TRACKS];
  cdq_entry_t mem_q_r;
  logic       mem_we, mem_re;
  logic [7:0] wr_t, rd_t;
  cdq_entry_t mem_wd;

  logic [3:0]         state_r, state_nxt;
  logic [6:0]         first_r, first_nxt, count_r, count_nxt;
  logic signed [19:0] addr_r, addr_nxt, st_r, st_nxt;
  logic [19:0]        len_r, len_nxt;
  logic [7:0]         t_r, t_nxt, end_r, end_nxt;
  logic [6:0]         hit_r, hit_nxt;
  logic [3:0]         ctrl_r, ctrl_nxt;
  logic               pause_r, pause_nxt, idx1_r, idx1_nxt;
  logic [1:0]         step_r, step_nxt;
  logic [7:0]         rel_m_r, rel_m_nxt, rel_s_r, rel_s_nxt, rel_f_r, rel_f_nxt;
  logic [7:0]         abs_m_r, abs_m_nxt, abs_s_r, abs_s_nxt, abs_f_r, abs_f_nxt;
  logic [15:0]        crc_r, crc_nxt;
  logic [3:0]         k_r, k_nxt;
  logic               out_valid_r, out_valid_nxt;
  cdq_out_t           out_r, out_nxt;
  logic               out_free;

  logic        div_start, div_done;
  logic [20:0] div_n, div_quot;
  logic [6:0]  div_d, div_rem;

  logic signed [22:0] addr_x, e_st_x, lo_x, hi_x, diff_x, st_x, rel_x;
  logic signed [22:0] abs_v, abs_x;
  logic               span_hit, need_prev;
  logic [7:0]         qb [Q_BYTES];
  logic [63:0]        word;

  cdq_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Entry span test against the query address; relative and absolute addresses.
  always_comb begin
    addr_x    = {{3{addr_r[19]}}, addr_r};
    e_st_x    = {{3{mem_q_r.start[19]}}, mem_q_r.start};
    lo_x      = e_st_x - $signed({3'b0, mem_q_r.lead_in});
    hi_x      = e_st_x + $signed({3'b0, mem_q_r.length}) + $signed({3'b0, mem_q_r.postgap});
    diff_x    = addr_x - e_st_x;
    span_hit  = (addr_x >= lo_x) && (addr_x < hi_x);
    // A data track entered from audio keeps the audio control deep in its pregap.
    need_prev = (diff_x < -23'sd150) && mem_q_r.control[2] &&
                (t_r > {1'b0, first_r}) && (t_r >= 8'd2);
    st_x      = {{3{st_r[19]}}, st_r};
    rel_x     = (addr_x < st_x) ? (st_x - 23'sd1 - addr_x) : (addr_x - st_x);
    abs_v     = addr_x + 23'(LEAD_OFS);
    if (abs_v < 23'sd0) begin
      abs_x = (abs_v < -23'(ABS_WRAP)) ? abs_v + 23'(2 * ABS_WRAP) : abs_v + 23'(ABS_WRAP);
    end else begin
      abs_x = (abs_v >= 23'(ABS_WRAP)) ? abs_v - 23'(ABS_WRAP) : abs_v;
    end
  end

  always_comb begin
    qb[0]  = {ctrl_r, ADR_POSITION};
    qb[1]  = to_bcd({1'b0, hit_r});
    qb[2]  = {7'd0, idx1_r};
    qb[3]  = rel_m_r;
    qb[4]  = rel_s_r;
    qb[5]  = rel_f_r;
    qb[6]  = 8'd0;
    qb[7]  = abs_m_r;
    qb[8]  = abs_s_r;
    qb[9]  = abs_f_r;
    qb[10] = ~crc_r[15:8];
    qb[11] = ~crc_r[7:0];
    for (int j = 0; j < 8; j++) begin
      word[8*j +: 8] = {pause_r, qb[k_r][7-j], 6'd0};
    end
  end

  assign out_free  = ~out_valid_r | ~out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    first_nxt     = first_r;
    count_nxt     = count_r;
    addr_nxt      = addr_r;
    st_nxt        = st_r;
    len_nxt       = len_r;
    t_nxt         = t_r;
    end_nxt       = end_r;
    hit_nxt       = hit_r;
    ctrl_nxt      = ctrl_r;
    pause_nxt     = pause_r;
    idx1_nxt      = idx1_r;
    step_nxt      = step_r;
    rel_m_nxt     = rel_m_r;
    rel_s_nxt     = rel_s_r;
    rel_f_nxt     = rel_f_r;
    abs_m_nxt     = abs_m_r;
    abs_s_nxt     = abs_s_r;
    abs_f_nxt     = abs_f_r;
    crc_nxt       = crc_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_nxt       = out_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    wr_t          = {1'b0, q_cmd.pl.track_number} - 8'd1;
    rd_t          = t_r - 8'd1;
    mem_wd        = '{start:   q_cmd.pl.track_start,
                      lead_in: q_cmd.pl.lead_in_length,
                      length:  q_cmd.pl.track_sectors,
                      postgap: q_cmd.pl.track_postgap,
                      control: q_cmd.pl.track_control};
    div_start     = 1'b0;
    div_n         = div_quot;
    div_d         = step_r[0] ? FRAMES_PER_SEC : SECS_PER_MIN;

    if (cfg_we) begin
      if (cfg_index == CFG_WIN_START) begin
        first_nxt = cfg_wdata;
      end else begin
        count_nxt = cfg_wdata;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          if (q_cmd.is_query) begin
            addr_nxt  = q_cmd.pl.query_address;
            t_nxt     = {1'b0, first_r};
            end_nxt   = {1'b0, first_r} + {1'b0, count_r};
            state_nxt = S_RD;
          end else begin
            mem_we = q_cmd.load_ok;
          end
        end
      end
      S_RD: begin
        if (t_r >= end_r) begin
          state_nxt = S_MISS;
        end else if ((t_r == 8'd0) || (t_r > 8'(MAX_TRACKS))) begin
          t_nxt = t_r + 8'd1;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (span_hit) begin
          hit_nxt  = t_r[6:0];
          st_nxt   = mem_q_r.start;
          len_nxt  = mem_q_r.length;
          ctrl_nxt = mem_q_r.control;
          if (need_prev) begin
            rd_t      = t_r - 8'd2;
            mem_re    = 1'b1;
            state_nxt = S_PCHK;
          end else begin
            state_nxt = S_PREP;
          end
        end else begin
          t_nxt     = t_r + 8'd1;
          state_nxt = S_RD;
        end
      end
      S_PCHK: begin
        if (!mem_q_r.control[2]) begin
          ctrl_nxt = mem_q_r.control;
        end
        state_nxt = S_PREP;
      end
      S_PREP: begin
        pause_nxt = (addr_x < st_x) || (addr_x >= st_x + $signed({3'b0, len_r}));
        idx1_nxt  = (addr_x >= st_x);
        div_start = 1'b1;
        div_n     = rel_x[20:0];
        div_d     = FRAMES_PER_SEC;
        step_nxt  = 2'd0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          step_nxt = step_r + 2'd1;
          unique case (step_r)
            2'd0: begin
              rel_f_nxt = to_bcd({1'b0, div_rem});
              div_start = 1'b1;
            end
            2'd1: begin
              rel_s_nxt = to_bcd({1'b0, div_rem});
              rel_m_nxt = to_bcd(div_quot[7:0]);
              div_start = 1'b1;
              div_n     = abs_x[20:0];
            end
            2'd2: begin
              abs_f_nxt = to_bcd({1'b0, div_rem});
              div_start = 1'b1;
            end
            default: begin
              abs_s_nxt = to_bcd({1'b0, div_rem});
              abs_m_nxt = to_bcd(div_quot[7:0]);
              crc_nxt   = 16'd0;
              k_nxt     = 4'd0;
              state_nxt = S_CRC;
            end
          endcase
        end
      end
      S_CRC: begin
        crc_nxt = crc_byte(crc_r, qb[k_r]);
        if (k_r == 4'(CRC_BYTES - 1)) begin
          k_nxt     = 4'd0;
          state_nxt = S_OUT;
        end else begin
          k_nxt = k_r + 4'd1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_nxt.subcode_word     = word;
          out_nxt.last             = (k_r == 4'(Q_BYTES - 1));
          out_nxt.found            = 1'b1;
          out_nxt.found_track      = hit_r;
          k_nxt                    = k_r + 4'd1;
          if (k_r == 4'(Q_BYTES - 1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_MISS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{subcode_word: 64'd0, last: 1'b1, found: 1'b0,
                            found_track: 7'd0};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_t[IW-1:0]] <= mem_wd;
    end
    if (mem_re) begin
      mem_q_r <= mem[rd_t[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= WIN_START_RST;
      count_r     <= 7'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r  <= addr_nxt;
    st_r    <= st_nxt;
    len_r   <= len_nxt;
    t_r     <= t_nxt;
    end_r   <= end_nxt;
    hit_r   <= hit_nxt;
    ctrl_r  <= ctrl_nxt;
    pause_r <= pause_nxt;
    idx1_r  <= idx1_nxt;
    step_r  <= step_nxt;
    rel_m_r <= rel_m_nxt;
    rel_s_r <= rel_s_nxt;
    rel_f_r <= rel_f_nxt;
    abs_m_r <= abs_m_nxt;
    abs_s_r <= abs_s_nxt;
    abs_f_r <= abs_f_nxt;
    crc_r   <= crc_nxt;
    k_r     <= k_nxt;
    out_r   <= out_nxt;
  end

  a_miss_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.found |-> out_r.last)
    else $error("not-found result without last flag");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == S_IDLE) && q_valid)
    else $error("queue popped outside idle");

  a_crc_before_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) && (k_r == 4'd0) && ($past(state_r) != S_OUT) |->
      ($past(state_r) == S_CRC))
    else $error("frame output started without CRC pass");

  a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> (k_r < 4'(Q_BYTES)))
    else $error("frame word counter out of range");

endmodule

// ----- rtl/core/cd_subcode_q_generator.sv -----
// Top level: subcode Q generator (front end, request queue, back end).
// A load passes the front-end register and the request queue before it is written to the table;
// a query passes the same two on its way to the back end. There it reads each searched track
// (skipping numbers outside the table), reads the preceding control if needed, does a setup step,
// runs four MSF divisions and a CRC over ten bytes, then gives 12 words. A miss gives its one result
// after the search. The back end takes one request at a time; the queue holds two.
// Reset (rst_n, synchronous, active low): search start 1, count 0; track table not cleared.
module cd_subcode_q_generator #(
  parameter int MAX_TRACKS = 99
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cdq_pkg::cdq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cdq_pkg::cdq_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [6:0]        cfg_wdata
);
  import cdq_pkg::*;

  logic     push, q_full, q_valid, pop;
  cdq_cmd_t push_cmd, q_cmd;

  cdq_front #(.MAX_TRACKS(MAX_TRACKS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  cdq_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  cdq_back #(.MAX_TRACKS(MAX_TRACKS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
